// ===== rtl/pfl_pkg.sv =====
`timescale 1ns / 1ps

package pfl_pkg;

  localparam int CORDIC_GUARD    = 8;
  localparam int COEF_WIDTH      = 16;
  localparam int COEF_FRAC       = 14;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOOP_GAIN     = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_COEF = 8'd1;

  localparam logic signed [COEF_WIDTH-1:0] LOOP_GAIN_RESET     = 16'sd9830;
  localparam logic signed [COEF_WIDTH-1:0] FEEDBACK_COEF_RESET = 16'sd0;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic adv;
    logic take;
  } stage_ctl_t;

endpackage

// ===== rtl/phase_diff_frequency_locker.sv =====
`timescale 1ns / 1ps
// Registers in order: pre-rotation, CORDIC cells, phase difference, product, output.
// Throughput: one word per cycle unless out_ready stalls; the multiply-accumulate
//   on the output register (previous output times feedback_coef) is one loop.
// Each pipeline stage advances on its own, so bubbles close up while a result is held.
// Reset (synchronous, rst_n low) clears the pipeline valid bits, previous phases,
//   previous output and sets loop_gain to 9830, feedback_coef to 0.

module phase_diff_frequency_locker #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int PHASE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_WIDTH     = 20
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_lo_in_phase,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_lo_quadrature,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_ref_in_phase,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_ref_quadrature,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [OUT_WIDTH-1:0]                 out_freq_control,
  output logic                                        out_saturated,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [pfl_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  logic [pfl_pkg::COEF_WIDTH-1:0]              cfg_data
);

  localparam int XW   = SAMPLE_WIDTH + pfl_pkg::CORDIC_GUARD + 3;
  localparam int NST  = CORDIC_STAGES + 4;
  localparam int DIFF = CORDIC_STAGES + 1;
  localparam int PROD = CORDIC_STAGES + 2;
  localparam int LAST = CORDIC_STAGES + 3;

  logic [NST-1:0] valid_r, adv;

  logic signed [pfl_pkg::COEF_WIDTH-1:0] loop_gain_r, feedback_coef_r;

  logic signed [SAMPLE_WIDTH-1:0] si [2];
  logic signed [SAMPLE_WIDTH-1:0] sq [2];

  logic signed [XW-1:0] xc [2][CORDIC_STAGES+1];
  logic signed [XW-1:0] yc [2][CORDIC_STAGES+1];
  logic [31:0]          zc [2][CORDIC_STAGES+1];
  logic                 zc_zero [2][CORDIC_STAGES+1];

  logic signed [XW-1:0] x0_r [2];
  logic signed [XW-1:0] y0_r [2];
  logic [31:0]          z0_r [2];
  logic                 zero0_r [2];

  logic signed [PHASE_WIDTH-1:0] err;
  pfl_pkg::stage_ctl_t diff_ctl, prod_ctl, out_ctl;

  // stall chain: a stage moves when it is empty or the next one moves
  assign adv[NST-1] = !valid_r[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !valid_r[k] || adv[k+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_gain_r     <= pfl_pkg::LOOP_GAIN_RESET;
      feedback_coef_r <= pfl_pkg::FEEDBACK_COEF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfl_pkg::REG_LOOP_GAIN:     loop_gain_r     <= cfg_data;
        pfl_pkg::REG_FEEDBACK_COEF: feedback_coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign si[0] = in_lo_in_phase;
  assign sq[0] = in_lo_quadrature;
  assign si[1] = in_ref_in_phase;
  assign sq[1] = in_ref_quadrature;

  // pre-rotation: left half plane turned by a half turn
  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    logic signed [XW-1:0] xg, yg;
    logic                 neg;

    assign xg  = XW'(si[ch]) <<< pfl_pkg::CORDIC_GUARD;
    assign yg  = XW'(sq[ch]) <<< pfl_pkg::CORDIC_GUARD;
    assign neg = si[ch][SAMPLE_WIDTH-1];

    always_ff @(posedge clk) begin
      if (adv[0]) begin
        x0_r[ch]    <= neg ? -xg : xg;
        y0_r[ch]    <= neg ? -yg : yg;
        z0_r[ch]    <= neg ? pfl_pkg::HALF_TURN : '0;
        zero0_r[ch] <= (si[ch] == '0) && (sq[ch] == '0);
      end
    end

    assign xc[ch][0]      = x0_r[ch];
    assign yc[ch][0]      = y0_r[ch];
    assign zc[ch][0]      = z0_r[ch];
    assign zc_zero[ch][0] = zero0_r[ch];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
      pfl_cordic_cell #(
        .XW    (XW),
        .SHIFT (s)
      ) u_cell (
        .clk    (clk),
        .en     (adv[s+1]),
        .x_i    (xc[ch][s]),
        .y_i    (yc[ch][s]),
        .z_i    (zc[ch][s]),
        .zero_i (zc_zero[ch][s]),
        .x_o    (xc[ch][s+1]),
        .y_o    (yc[ch][s+1]),
        .z_o    (zc[ch][s+1]),
        .zero_o (zc_zero[ch][s+1])
      );
    end
  end

  assign diff_ctl.adv  = adv[DIFF];
  assign diff_ctl.take = adv[DIFF] && valid_r[DIFF-1];
  assign prod_ctl.adv  = adv[PROD];
  assign prod_ctl.take = adv[PROD] && valid_r[PROD-1];
  assign out_ctl.adv   = adv[LAST];
  assign out_ctl.take  = adv[LAST] && valid_r[LAST-1];

  pfl_phase_diff #(
    .PW (PHASE_WIDTH)
  ) u_diff (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (diff_ctl),
    .z_lo_i     (zc[0][CORDIC_STAGES]),
    .z_ref_i    (zc[1][CORDIC_STAGES]),
    .zero_lo_i  (zc_zero[0][CORDIC_STAGES]),
    .zero_ref_i (zc_zero[1][CORDIC_STAGES]),
    .err_o      (err)
  );

  pfl_loop_filter #(
    .PW (PHASE_WIDTH),
    .OW (OUT_WIDTH)
  ) u_filter (
    .clk             (clk),
    .rst_n           (rst_n),
    .prod_ctl        (prod_ctl),
    .out_ctl         (out_ctl),
    .err_i           (err),
    .loop_gain_i     (loop_gain_r),
    .feedback_coef_i (feedback_coef_r),
    .freq_o          (out_freq_control),
    .sat_o           (out_saturated)
  );

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_ready_passes_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_accept_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0])
    else $error("accepted word lost at first stage");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_freq_control == {1'b0, {(OUT_WIDTH-1){1'b1}}}) ||
      (out_freq_control == {1'b1, {(OUT_WIDTH-1){1'b0}}}))
    else $error("saturation flag without clipped value");

endmodule

// ===== rtl/pfl_cordic_cell.sv =====
`timescale 1ns / 1ps

module pfl_cordic_cell #(
  parameter int XW    = 27,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          z_i,
  input  logic                 zero_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [31:0]          z_o,
  output logic                 zero_o
);

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_nxt, y_nxt, x_r, y_r;
  logic [31:0]          z_nxt, z_r;
  logic                 zero_r;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + pfl_pkg::ATAN_TURN32[SHIFT];
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - pfl_pkg::ATAN_TURN32[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign zero_o = zero_r;

endmodule

// ===== rtl/pfl_phase_diff.sv =====
`timescale 1ns / 1ps

module pfl_phase_diff #(
  parameter int PW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfl_pkg::stage_ctl_t  ctl,
  input  logic [31:0]          z_lo_i,
  input  logic [31:0]          z_ref_i,
  input  logic                 zero_lo_i,
  input  logic                 zero_ref_i,
  output logic signed [PW-1:0] err_o
);

  localparam logic [31:0] RND = 32'(1) << (31 - PW);

  logic [31:0]          zr_lo, zr_ref;
  logic [PW-1:0]        ph_lo, ph_ref, d_lo, d_ref;
  logic [PW-1:0]        last_lo_r, last_ref_r;
  logic signed [PW-1:0] err_nxt, err_r;

  assign zr_lo  = z_lo_i + RND;
  assign zr_ref = z_ref_i + RND;
  assign ph_lo  = zero_lo_i  ? '0 : zr_lo[31 -: PW];
  assign ph_ref = zero_ref_i ? '0 : zr_ref[31 -: PW];
  assign d_lo   = ph_lo - last_lo_r;
  assign d_ref  = ph_ref - last_ref_r;
  assign err_nxt = d_ref - d_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lo_r  <= '0;
      last_ref_r <= '0;
    end else if (ctl.take) begin
      last_lo_r  <= ph_lo;
      last_ref_r <= ph_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      err_r <= err_nxt;
    end
  end

  assign err_o = err_r;

endmodule

// ===== rtl/pfl_loop_filter.sv =====
`timescale 1ns / 1ps

module pfl_loop_filter #(
  parameter int PW = 16,
  parameter int OW = 20
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pfl_pkg::stage_ctl_t                     prod_ctl,
  input  pfl_pkg::stage_ctl_t                     out_ctl,
  input  logic signed [PW-1:0]                    err_i,
  input  logic signed [pfl_pkg::COEF_WIDTH-1:0]   loop_gain_i,
  input  logic signed [pfl_pkg::COEF_WIDTH-1:0]   feedback_coef_i,
  output logic signed [OW-1:0]                    freq_o,
  output logic                                    sat_o
);

  localparam int PRW = PW + pfl_pkg::COEF_WIDTH;
  localparam int FBW = OW + pfl_pkg::COEF_WIDTH;
  localparam int AW  = ((PRW > FBW) ? PRW : FBW) + 2;
  localparam int RW  = AW - pfl_pkg::COEF_FRAC;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (pfl_pkg::COEF_FRAC - 1);
  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  logic signed [PRW-1:0] prod_nxt, prod_r;
  logic signed [FBW-1:0] fb_prod;
  logic signed [AW-1:0]  acc;
  logic signed [RW-1:0]  res;
  logic                  fits;
  logic signed [OW-1:0]  freq_nxt, freq_r;
  logic                  sat_nxt, sat_r;

  assign prod_nxt = PRW'(err_i) * PRW'(loop_gain_i);

  always_ff @(posedge clk) begin
    if (prod_ctl.adv) begin
      prod_r <= prod_nxt;
    end
  end

  // recurrent path: previous output times feedback
  assign fb_prod = FBW'(freq_r) * FBW'(feedback_coef_i);
  assign acc     = AW'(prod_r) + AW'(fb_prod) + HALF;
  assign res     = acc[AW-1:pfl_pkg::COEF_FRAC];
  assign fits    = (res[RW-1:OW-1] == '0) || (res[RW-1:OW-1] == '1);

  always_comb begin
    if (fits) begin
      freq_nxt = res[OW-1:0];
      sat_nxt  = 1'b0;
    end else begin
      freq_nxt = res[RW-1] ? OUT_MIN : OUT_MAX;
      sat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= '0;
      sat_r  <= 1'b0;
    end else if (out_ctl.take) begin
      freq_r <= freq_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign freq_o = freq_r;
  assign sat_o  = sat_r;

endmodule
